// ===== hw/rtl/tcgq_pkg.sv =====
package tcgq_pkg;

  localparam int ROLE_COUNT          = 3;
  localparam int ID_WIDTH            = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_ID_BITS     = 16;

  // operation codes
  localparam logic [1:0] OP_PUSH      = 2'd0;
  localparam logic [1:0] OP_POP_GROUP = 2'd1;
  localparam logic [1:0] OP_POP_ROLE  = 2'd2;
  localparam logic [1:0] OP_PEEK      = 2'd3;

  // role codes
  localparam logic [1:0] ROLE_DEFENDER = 2'd0;
  localparam logic [1:0] ROLE_HUNTER   = 2'd1;
  localparam logic [1:0] ROLE_BARD     = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/tcgq_cell.sv =====
module tcgq_cell #(
  parameter int DATA_BITS = tcgq_pkg::DEFAULT_ID_BITS
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 shift,
  input  logic [DATA_BITS-1:0] load_data,
  input  logic [DATA_BITS-1:0] shift_data,
  output logic [DATA_BITS-1:0] data
);

  // load takes a new tail entry, shift takes the neighbor toward the tail
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_data;
    end
  end

endmodule

// ===== hw/rtl/tcgq_lane.sv =====
module tcgq_lane #(
  parameter int QUEUE_DEPTH = tcgq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int DATA_BITS   = tcgq_pkg::DEFAULT_ID_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcgq_pkg::lane_ctrl_t               ctrl,
  input  logic [DATA_BITS-1:0]               wr_data,
  output logic [DATA_BITS-1:0]               head,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill
);
  import tcgq_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] cell_data [QUEUE_DEPTH];

  // cell 0 is the head; a pop moves every entry one cell toward the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DATA_BITS-1:0] neighbor;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign neighbor = cell_data[i];
    end else begin : g_mid
      assign neighbor = cell_data[i+1];
    end

    tcgq_cell #(
      .DATA_BITS(DATA_BITS)
    ) u_cell (
      .clk       (clk),
      .load      (ctrl.push && (fill == FILL_W'(i))),
      .shift     (ctrl.pop),
      .load_data (wr_data),
      .shift_data(neighbor),
      .data      (cell_data[i])
    );
  end

  assign head = cell_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.push) begin
      fill <= fill + FILL_W'(1);
    end else if (ctrl.pop) begin
      fill <= fill - FILL_W'(1);
    end
  end

endmodule

// ===== hw/rtl/three_class_group_queue_top.sv =====
// Latency: a result appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the input is not stalled; each queue's
// row of cells writes its tail cell or shifts toward its head.
// The input stalls only while a finished result waits under output stall.
// Reset clears all queue fills and the output valid; cell contents are not
// cleared and are never shown before a push writes them.
module three_class_group_queue_top #(
  parameter int QUEUE_DEPTH = tcgq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int ID_BITS     = tcgq_pkg::DEFAULT_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [1:0]                    role,
  input  logic [tcgq_pkg::ID_WIDTH-1:0] player_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [2:0]                    front_valid,
  output logic [tcgq_pkg::ID_WIDTH-1:0] front_defender,
  output logic [tcgq_pkg::ID_WIDTH-1:0] front_hunter,
  output logic [tcgq_pkg::ID_WIDTH-1:0] front_bard,
  output logic                          group_ready,
  output logic [5:0]                    total_count
);
  import tcgq_pkg::*;

  // identifiers keep at most the low ID_WIDTH bits of the port
  localparam int STORE_BITS = (ID_BITS < ID_WIDTH) ? ID_BITS : ID_WIDTH;
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W      = FILL_W + 2;

  logic                  accept;
  logic [STORE_BITS-1:0] wr_data;
  lane_ctrl_t            ctrl       [ROLE_COUNT];
  logic [STORE_BITS-1:0] head       [ROLE_COUNT];
  logic [FILL_W-1:0]     fill       [ROLE_COUNT];
  logic [FILL_W-1:0]     fill_after [ROLE_COUNT];
  logic [ROLE_COUNT-1:0] role_sel;
  logic [ROLE_COUNT-1:0] nonempty;
  logic [ROLE_COUNT-1:0] full;
  logic [ROLE_COUNT-1:0] nonempty_after;
  logic [1:0]            status_next;
  logic [SUM_W-1:0]      sum_next;

  // a result waiting under stall holds the input; otherwise take an item
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign wr_data  = player_id[STORE_BITS-1:0];

  for (genvar r = 0; r < ROLE_COUNT; r++) begin : g_role
    assign role_sel[r]       = (role == 2'(r));
    assign nonempty[r]       = (fill[r] != '0);
    assign full[r]           = (fill[r] == FILL_W'(QUEUE_DEPTH));
    assign fill_after[r]     = fill[r] + FILL_W'(ctrl[r].push) - FILL_W'(ctrl[r].pop);
    assign nonempty_after[r] = (fill_after[r] != '0);

    tcgq_lane #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .DATA_BITS  (STORE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl[r]),
      .wr_data(wr_data),
      .head   (head[r]),
      .fill   (fill[r])
    );
  end

  // decode the operation into per-lane push and pop strobes
  always_comb begin
    status_next = STATUS_DONE;
    for (int r = 0; r < ROLE_COUNT; r++) begin
      ctrl[r] = '0;
    end
    unique case (opcode)
      OP_PUSH: begin
        if ((role_sel & ~full) != '0) begin
          for (int r = 0; r < ROLE_COUNT; r++) begin
            ctrl[r].push = accept && role_sel[r];
          end
        end else begin
          // full queue or no such role: drop the identifier
          status_next = STATUS_FULL;
        end
      end
      OP_POP_GROUP: begin
        if (&nonempty) begin
          for (int r = 0; r < ROLE_COUNT; r++) begin
            ctrl[r].pop = accept;
          end
        end else begin
          status_next = STATUS_EMPTY;
        end
      end
      OP_POP_ROLE: begin
        if ((role_sel & nonempty) != '0) begin
          for (int r = 0; r < ROLE_COUNT; r++) begin
            ctrl[r].pop = accept && role_sel[r];
          end
        end else begin
          status_next = STATUS_EMPTY;
        end
      end
      OP_PEEK: begin
        status_next = STATUS_DONE;
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  // total after the step, kept modulo the output width
  assign sum_next = SUM_W'(fill_after[0]) + SUM_W'(fill_after[1]) + SUM_W'(fill_after[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && out_stall);
    end
  end

  // result payload: fronts are the heads as they stood before the step
  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= status_next;
      front_valid    <= nonempty;
      front_defender <= nonempty[0] ? ID_WIDTH'(head[0]) : '0;
      front_hunter   <= nonempty[1] ? ID_WIDTH'(head[1]) : '0;
      front_bard     <= nonempty[2] ? ID_WIDTH'(head[2]) : '0;
      group_ready    <= &nonempty_after;
      total_count    <= 6'(sum_next);
    end
  end

endmodule

// ===== hw/rtl/tcgq_checker.sv =====
module tcgq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    status,
  input logic [2:0]                    front_valid,
  input logic [tcgq_pkg::ID_WIDTH-1:0] front_defender,
  input logic [tcgq_pkg::ID_WIDTH-1:0] front_hunter,
  input logic [tcgq_pkg::ID_WIDTH-1:0] front_bard,
  input logic                          group_ready,
  input logic [5:0]                    total_count
);
  import tcgq_pkg::*;

  // every accepted item yields a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // the input stalls only behind a result that is itself stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // an empty queue reports a zero front
  a_empty_front_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (front_valid[0] || front_defender == '0)
               && (front_valid[1] || front_hunter == '0)
               && (front_valid[2] || front_bard == '0))
    else $error("front of an empty queue is not zero");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(front_valid)
                               && $stable(total_count) && $stable(group_ready))
    else $error("stalled result changed");

endmodule

bind three_class_group_queue_top tcgq_checker u_tcgq_checker (.*);
